### src/dfmt_pkg.sv
`default_nettype none

package dfmt_pkg;

    // fixed geometry of the number field
    localparam int NUM_DIGITS      = 6;
    localparam int VALUE_W         = 20;
    localparam int BCD_W           = 4 * NUM_DIGITS;
    localparam int DD_STAGES       = 4;
    localparam int DD_BITS_PER_STG = VALUE_W / DD_STAGES;
    localparam int MAX_ITEMS       = 8;
    localparam int GLYPH_WIDTH_DEF = 8;

    localparam logic [VALUE_W-1:0] TOP_VALUE  = 20'd999999;
    localparam logic [7:0]         DIGIT_BASE = 8'h30;
    localparam logic [7:0]         COMMA_CODE = 8'h2C;
    localparam logic [2:0]         COMMA_MAX  = 3'd5;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_ROW_POSITION = 2'd0;
    localparam logic [1:0] REG_TEXT_COLOUR  = 2'd1;
    localparam logic [1:0] REG_BACK_COLOUR  = 2'd2;
    localparam logic [1:0] REG_PANEL_SELECT = 2'd3;

    typedef struct packed {
        logic [19:0] number_value;
        logic [2:0]  comma_place;
        logic [7:0]  pad_char;
        logic [3:0]  field_width;
        logic [7:0]  start_x;
        logic [2:0]  scale_minus_one;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] char_x;
        logic       last_char;
        logic       overflow;
    } t_out_item;

    // fields riding along the conversion stages
    typedef struct packed {
        logic [2:0] comma;
        logic [7:0] pad;
        logic [3:0] width;
        logic [7:0] x;
        logic [2:0] scale;
        logic       ovf;
    } t_side;

    // double-dabble working pair
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } t_dd;

    // everything the serializer needs for one number
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [2:0]       ndig;
        logic [3:0]       npad;
        logic [2:0]       comma;
        logic [7:0]       pad;
        logic [7:0]       x;
        logic [7:0]       step;
        logic [5:0]       cstep;
        logic             ovf;
    } t_plan;

    // one pipeline stage worth of shift-add-3 steps
    function automatic t_dd dd_steps(input t_dd a);
        t_dd r;
        r = a;
        for (int s = 0; s < DD_BITS_PER_STG; s++) begin
            for (int n = 0; n < NUM_DIGITS; n++) begin
                if (r.bcd[n*4 +: 4] >= 4'd5) begin
                    r.bcd[n*4 +: 4] = r.bcd[n*4 +: 4] + 4'd3;
                end
            end
            r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
            r.bin = {r.bin[VALUE_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/dfmt_pipe.sv
`default_nettype none

module dfmt_pipe #(
    parameter int GLYPH_WIDTH = dfmt_pkg::GLYPH_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dfmt_pkg::t_in_item i_item,
    output logic               o_plan_valid,
    input  logic               i_plan_ready,
    output dfmt_pkg::t_plan    o_plan
);
    import dfmt_pkg::*;

    // stage 0 captures, stages 1..DD_STAGES convert, then the plan stage
    localparam int NSTG = DD_STAGES + 1;

    logic [NSTG-1:0] r_v;
    t_dd             r_dd   [NSTG];
    t_side           r_side [NSTG];
    logic            r_pv;
    t_plan           r_plan;

    logic [NSTG-1:0] rdy;
    logic            p_rdy;
    t_dd             n_dd0;
    t_side           n_side0;
    t_plan           n_plan;

    always_comb begin
        p_rdy = !r_pv || i_plan_ready;
        rdy[NSTG-1] = !r_v[NSTG-1] || p_rdy;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];

    // saturate and clamp on the way in
    always_comb begin
        n_side0.ovf   = (i_item.number_value > TOP_VALUE);
        n_side0.comma = (i_item.comma_place > COMMA_MAX) ? 3'd0 : i_item.comma_place;
        n_side0.pad   = i_item.pad_char;
        n_side0.width = i_item.field_width;
        n_side0.x     = i_item.start_x;
        n_side0.scale = i_item.scale_minus_one;
        n_dd0.bcd     = '0;
        n_dd0.bin     = n_side0.ovf ? TOP_VALUE : i_item.number_value;
    end

    // digit count, pad count and advances
    always_comb begin
        logic [2:0] top;
        logic [2:0] forced;
        logic [2:0] ndig;
        logic [3:0] npad;
        logic [3:0] room;
        logic       hc;
        top = 3'd1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_dd[NSTG-1].bcd[i*4 +: 4] != 4'd0) begin
                top = 3'(i + 1);
            end
        end
        hc     = (r_side[NSTG-1].comma != 3'd0);
        forced = hc ? (r_side[NSTG-1].comma + 3'd1) : 3'd1;
        ndig   = (top > forced) ? top : forced;
        if (ndig == 3'(NUM_DIGITS)) begin
            npad = 4'd0;
        end else if (ndig == 3'(NUM_DIGITS - 1)) begin
            npad = (r_side[NSTG-1].width == 4'(NUM_DIGITS)) ? 4'd1 : 4'd0;
        end else if (r_side[NSTG-1].width > {1'b0, ndig}) begin
            npad = r_side[NSTG-1].width - {1'b0, ndig};
        end else begin
            npad = 4'd0;
        end
        room = 4'(MAX_ITEMS) - {1'b0, ndig} - {3'd0, hc};
        if (npad > room) begin
            npad = room;
        end
        n_plan.bcd   = r_dd[NSTG-1].bcd;
        n_plan.ndig  = ndig;
        n_plan.npad  = npad;
        n_plan.comma = r_side[NSTG-1].comma;
        n_plan.pad   = r_side[NSTG-1].pad;
        n_plan.x     = r_side[NSTG-1].x;
        n_plan.step  = 8'(GLYPH_WIDTH * (int'(r_side[NSTG-1].scale) + 1));
        n_plan.cstep = {4'({1'b0, r_side[NSTG-1].scale} + 4'd1), 2'b00};
        n_plan.ovf   = r_side[NSTG-1].ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_pv <= 1'b0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (p_rdy) begin
                r_pv <= r_v[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_dd[0]   <= n_dd0;
            r_side[0] <= n_side0;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (rdy[k]) begin
                r_dd[k]   <= dd_steps(r_dd[k-1]);
                r_side[k] <= r_side[k-1];
            end
        end
        if (p_rdy) begin
            r_plan <= n_plan;
        end
    end

    assign o_plan_valid = r_pv;
    assign o_plan       = r_plan;

    a_ovf_all_nines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv && r_plan.ovf |-> r_plan.bcd == 24'h999999)
        else $error("saturated number did not convert to all nines");

    a_item_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> r_plan.ndig != 3'd0 && r_plan.ndig <= 3'(NUM_DIGITS)
              && (r_plan.npad + 4'(r_plan.ndig) + 4'(r_plan.comma != 3'd0))
                 <= 4'(MAX_ITEMS))
        else $error("plan exceeds character budget");

    a_plan_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv && !i_plan_ready |=> r_pv && $stable(r_plan))
        else $error("waiting plan changed or dropped");

endmodule

`default_nettype wire

### src/dfmt_ser.sv
`default_nettype none

module dfmt_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_plan_valid,
    output logic                o_plan_ready,
    input  dfmt_pkg::t_plan     i_plan,
    output logic                o_valid,
    input  logic                i_stall,
    output dfmt_pkg::t_out_item o_item
);
    import dfmt_pkg::*;

    logic             r_busy;
    logic [2:0]       r_idx;
    logic [3:0]       r_npad;
    logic             r_cpend;
    logic [BCD_W-1:0] r_bcd;
    logic [2:0]       r_comma;
    logic [7:0]       r_pad;
    logic [7:0]       r_x;
    logic [7:0]       r_step;
    logic [5:0]       r_cstep;
    logic             r_ovf;
    logic             r_ov;
    t_out_item        r_o;

    logic       out_free;
    logic       emit;
    logic       load;
    logic [2:0] didx;
    logic [3:0] digit;
    t_out_item  cur;
    logic [7:0] adv;

    assign out_free = !r_ov || !i_stall;
    assign emit     = r_busy && out_free;
    assign didx     = r_idx - 3'd1;
    assign digit    = r_bcd[{didx, 2'b00} +: 4];

    // current character: pads first, then digits with the comma slotted in
    always_comb begin
        cur.char_x   = r_x;
        cur.overflow = r_ovf;
        if (r_npad != 4'd0) begin
            cur.char_code = r_pad;
            cur.last_char = 1'b0;
            adv           = r_step;
        end else if (r_cpend) begin
            cur.char_code = COMMA_CODE;
            cur.last_char = 1'b0;
            adv           = {2'b00, r_cstep};
        end else begin
            cur.char_code = DIGIT_BASE + {4'd0, digit};
            cur.last_char = (r_idx == 3'd1);
            adv           = r_step;
        end
    end

    assign load         = i_plan_valid && (!r_busy || (emit && cur.last_char));
    assign o_plan_ready = !r_busy || (emit && cur.last_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= 3'd0;
            r_npad  <= 4'd0;
            r_cpend <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (out_free) begin
                r_ov <= emit;
            end
            if (load) begin
                r_busy  <= 1'b1;
                r_idx   <= i_plan.ndig;
                r_npad  <= i_plan.npad;
                r_cpend <= 1'b0;
            end else if (emit) begin
                if (r_npad != 4'd0) begin
                    r_npad <= r_npad - 4'd1;
                end else if (r_cpend) begin
                    r_cpend <= 1'b0;
                end else begin
                    r_idx   <= didx;
                    r_cpend <= (r_comma != 3'd0) && (didx == r_comma);
                    r_busy  <= !cur.last_char;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bcd   <= i_plan.bcd;
            r_comma <= i_plan.comma;
            r_pad   <= i_plan.pad;
            r_x     <= i_plan.x;
            r_step  <= i_plan.step;
            r_cstep <= i_plan.cstep;
            r_ovf   <= i_plan.ovf;
        end else if (emit) begin
            r_x <= r_x + adv;
        end
        if (emit) begin
            r_o <= cur;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_o;

    a_comma_after_pads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cpend |-> r_npad == 4'd0)
        else $error("comma pending while pads remain");

    a_busy_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx != 3'd0)
        else $error("serializer busy with no digit left");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o.last_char |->
            r_o.char_code >= DIGIT_BASE && r_o.char_code <= DIGIT_BASE + 8'd9)
        else $error("final character of a number is not a digit");

endmodule

`default_nettype wire

### src/decimal_field_formatter.sv
`default_nettype none

// decimal field formatter: turns one number into up to eight character
// transfers for a glyph drawer (pads, digits, optional comma, with x)
//
// input channel: i_in_valid / o_in_stall / i_in_data, one number per transfer
// output channel: o_out_valid / i_out_stall / o_out_data, one character per
//   transfer; last_char marks the final digit, overflow marks every character
//   of a number above 999999 that was shown as 999999
// config: apb-style port, row_position at 0x0, text_colour at 0x4,
//   back_colour at 0x8, panel_select at 0xc; pready is always high
//
// path: a number passes capture, four double-dabble stages of 5 bits each,
//   plan and serializer before its first character is valid
// throughput: the serializer sends one character per cycle while the output
//   is not stalled, and a number takes 1 to 8 characters (pads + digits +
//   comma); numbers follow each other with no gap, and the input takes a
//   number every cycle while the six-stage front pipeline has room
// reset: synchronous active low, empties every stage and sets the registers
//   to row 0, text 0xffff, back 0, panel 1
// stall: i_out_stall holds the output register; the serializer then waits,
//   the front pipeline fills up and o_in_stall rises; nothing is dropped
module decimal_field_formatter #(
    parameter int GLYPH_WIDTH = dfmt_pkg::GLYPH_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // number in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dfmt_pkg::t_in_item            i_in_data,
    // characters out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dfmt_pkg::t_out_item           o_out_data,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfmt_pkg::ADDR_W-1:0]   paddr,
    input  logic [dfmt_pkg::DATA_W-1:0]   pwdata,
    output logic [dfmt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import dfmt_pkg::*;

    // settings for the glyph drawer, held here
    logic [7:0]  r_row_position;
    logic [15:0] r_text_colour;
    logic [15:0] r_back_colour;
    logic [1:0]  r_panel_select;

    logic [1:0] reg_idx;
    logic       wr_en;

    // link between conversion pipeline and serializer
    logic  plan_valid;
    logic  plan_ready;
    t_plan plan;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_position <= 8'd0;
            r_text_colour  <= 16'hFFFF;
            r_back_colour  <= 16'd0;
            r_panel_select <= 2'd1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ROW_POSITION: r_row_position <= pwdata[7:0];
                REG_TEXT_COLOUR:  r_text_colour  <= pwdata[15:0];
                REG_BACK_COLOUR:  r_back_colour  <= pwdata[15:0];
                REG_PANEL_SELECT: r_panel_select <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_ROW_POSITION: prdata = {24'd0, r_row_position};
            REG_TEXT_COLOUR:  prdata = {16'd0, r_text_colour};
            REG_BACK_COLOUR:  prdata = {16'd0, r_back_colour};
            REG_PANEL_SELECT: prdata = {30'd0, r_panel_select};
            default:          prdata = '0;
        endcase
    end

    // saturate, binary to bcd, then digit/pad counts
    dfmt_pipe #(
        .GLYPH_WIDTH (GLYPH_WIDTH)
    ) u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_item       (i_in_data),
        .o_plan_valid (plan_valid),
        .i_plan_ready (plan_ready),
        .o_plan       (plan)
    );

    // one character per cycle into the output register while the output is not stalled
    dfmt_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (plan_valid),
        .o_plan_ready (plan_ready),
        .i_plan       (plan),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_item       (o_out_data)
    );

endmodule

`default_nettype wire
